>>> rtl/tlik_pkg.sv
// Shared types and constants for the two-link planar arm inverse kinematics block.
// No dependencies; used by tlik_atan2 and the top level.
`default_nettype none

package tlik_pkg;

  localparam int COORD_BITS_DEF = 16;

  // atan2 unit
  localparam int ATAN_W       = 48;  // input vector width
  localparam int CW           = 34;  // rotator width after normalisation
  localparam int ZW           = 32;  // angle accumulator, 2^-16 degree
  localparam int CORDIC_STEPS = 22;
  localparam int NORM_STAGES  = 12;  // input reg, 5 right, 1 final right, 5 left
  localparam int ATAN_LAT     = NORM_STAGES + 1 + CORDIC_STEPS;

  localparam int ANG_ONE   = 65536;
  localparam int FULL_TURN = 23040;
  localparam int HALF_TURN = 11520;

  // square root unit: one result bit per stage
  localparam int SQ_STEPS = 31;
  localparam int RAD_W    = 2 * SQ_STEPS;

  localparam logic [22:0] ATAN_TAB [CORDIC_STEPS] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
    23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833, 23'd917,
    23'd458, 23'd229, 23'd115, 23'd57, 23'd29, 23'd14, 23'd7, 23'd4, 23'd2
  };

  typedef enum logic [1:0] {
    REG_LINK_ONE = 2'd0,
    REG_LINK_TWO = 2'd1,
    REG_SING_OFS = 2'd2,
    REG_SH_LIMIT = 2'd3
  } reg_idx_t;

endpackage

`default_nettype wire

>>> rtl/tlik_atan2.sv
// Pipelined atan2: normalise, fold into the right half plane, vectoring CORDIC.
// Depends on tlik_pkg. Takes one vector per cycle while en is high.
`default_nettype none

module tlik_atan2 import tlik_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [ATAN_W-1:0] y,
  input  wire logic signed [ATAN_W-1:0] x,
  output logic signed [ZW-1:0]          z
);

  localparam logic signed [ATAN_W-1:0] BIG = ATAN_W'(64'd1 << 30);

  function automatic logic is_big(input logic signed [ATAN_W-1:0] v);
    return (v >= BIG) || (v <= -BIG);
  endfunction

  logic signed [ATAN_W-1:0] nx [0:NORM_STAGES-1];
  logic signed [ATAN_W-1:0] ny [0:NORM_STAGES-1];
  logic signed [CW-1:0]     cx [0:CORDIC_STEPS];
  logic signed [CW-1:0]     cy [0:CORDIC_STEPS];
  logic signed [ZW-1:0]     cz [0:CORDIC_STEPS];
  logic                     sp_f [0:ATAN_LAT-1];
  logic signed [ZW-1:0]     sp_z [0:ATAN_LAT-1];

  // axis cases give exact answers
  logic signed [ZW-1:0] spec_z;
  always_comb begin
    if (y == '0) begin
      spec_z = (x < 0) ? ZW'(180 * ANG_ONE) : '0;
    end else if (y > 0) begin
      spec_z = ZW'(90 * ANG_ONE);
    end else begin
      spec_z = -ZW'(90 * ANG_ONE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx[0]   <= x;
      ny[0]   <= y;
      sp_f[0] <= (y == '0) || (x == '0);
      sp_z[0] <= spec_z;
      for (int s = 1; s < ATAN_LAT; s++) begin
        sp_f[s] <= sp_f[s-1];
        sp_z[s] <= sp_z[s-1];
      end
    end
  end

  // coarse right shifts: largest shift that still leaves a big component
  for (genvar j = 1; j <= 5; j++) begin : g_right
    localparam int RS = 1 << (5 - j);
    logic signed [ATAN_W-1:0] tx, ty;
    assign tx = nx[j-1] >>> RS;
    assign ty = ny[j-1] >>> RS;
    always_ff @(posedge clk) begin
      if (en) begin
        if (is_big(tx) || is_big(ty)) begin
          nx[j] <= tx;
          ny[j] <= ty;
        end else begin
          nx[j] <= nx[j-1];
          ny[j] <= ny[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (is_big(nx[5]) || is_big(ny[5])) begin
        nx[6] <= nx[5] >>> 1;
        ny[6] <= ny[5] >>> 1;
      end else begin
        nx[6] <= nx[5];
        ny[6] <= ny[5];
      end
    end
  end

  // left shifts up to magnitude in [2^29, 2^30)
  for (genvar j = 7; j < NORM_STAGES; j++) begin : g_left
    localparam int LS = 1 << (11 - j);
    localparam logic signed [ATAN_W-1:0] LIM = ATAN_W'(64'd1 << (30 - LS));
    logic ok;
    assign ok = (nx[j-1] < LIM) && (nx[j-1] > -LIM) && (ny[j-1] < LIM) && (ny[j-1] > -LIM);
    always_ff @(posedge clk) begin
      if (en) begin
        if (ok) begin
          nx[j] <= nx[j-1] <<< LS;
          ny[j] <= ny[j-1] <<< LS;
        end else begin
          nx[j] <= nx[j-1];
          ny[j] <= ny[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (nx[NORM_STAGES-1] < 0) begin
        cx[0] <= -CW'(nx[NORM_STAGES-1]);
        cy[0] <= -CW'(ny[NORM_STAGES-1]);
        cz[0] <= ZW'(180 * ANG_ONE);
      end else begin
        cx[0] <= CW'(nx[NORM_STAGES-1]);
        cy[0] <= CW'(ny[NORM_STAGES-1]);
        cz[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (cy[i] > 0) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + ZW'(ATAN_TAB[i]);
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - ZW'(ATAN_TAB[i]);
        end
      end
    end
  end

  assign z = sp_f[ATAN_LAT-1] ? sp_z[ATAN_LAT-1] : cz[CORDIC_STEPS];

endmodule

`default_nettype wire

>>> rtl/two_link_planar_inverse_kinematics.sv
// Top level of the two-link planar arm inverse kinematics block.
// Depends on tlik_pkg and tlik_atan2.
`default_nettype none

// Takes a target (x, y) word and returns shoulder and elbow angles in 1/64 degree
// with four status flags. Fully pipelined: a new target may enter every cycle that
// the output is not stalled; each target passes through 7 front stages, 31 square
// root stages, 2 for the shoulder correction vector, 35 in the atan2 units and 4 for
// rounding, wrap and limits. The whole pipe holds on a stalled output; the last
// stage is the output register. Link lengths, singularity margin and shoulder limit
// sit on an APB-style port at byte addresses 0, 4, 8 and 12 and must only be written
// with the pipe empty; derived link terms are registered from them, cfg_k after cfg_d.
module two_link_planar_inverse_kinematics import tlik_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // target_x, target_y (COORD_BITS each), zero pad to whole bytes
  input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]    s_tdata,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // shoulder_angle [14:0], elbow_angle [28:15], zero pad
  output logic [31:0]                               m_tdata,
  // beyond_reach, shoulder_clamped, bent_singularity, extended_singularity
  output logic [3:0]                                m_tuser,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [3:0]                           paddr,
  input  wire logic [31:0]                          pwdata,
  output logic [31:0]                               prdata,
  output logic                                      pready
);

  localparam int CB    = COORD_BITS;
  localparam int RW    = (2*CB+1 > 30) ? 2*CB+1 : 30;
  localparam int ER_W  = ZW + 1 - 10;
  // stage numbers
  localparam int S_UV  = 6;
  localparam int S_SQE = 7 + SQ_STEPS;
  localparam int S_MUL = S_SQE + 1;
  localparam int S_SUM = S_MUL + 1;
  localparam int S_AT  = S_SUM + ATAN_LAT;
  localparam int S_R1  = S_AT + 1;
  localparam int S_R2  = S_AT + 2;
  localparam int S_R3  = S_AT + 3;
  localparam int S_OUT = S_AT + 4;

  // ---------------- configuration ----------------
  logic [13:0] l1, l2;
  logic [5:0]  ofs_deg;
  logic [8:0]  lim_deg;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      l1      <= 14'd6502;
      l2      <= 14'd6502;
      ofs_deg <= 6'd10;
      lim_deg <= 9'd270;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_LINK_ONE: l1      <= pwdata[13:0];
        REG_LINK_TWO: l2      <= pwdata[13:0];
        REG_SING_OFS: ofs_deg <= pwdata[5:0];
        REG_SH_LIMIT: lim_deg <= pwdata[8:0];
        default:      l1      <= l1;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_LINK_ONE: prdata = {18'd0, l1};
      REG_LINK_TWO: prdata = {18'd0, l2};
      REG_SING_OFS: prdata = {26'd0, ofs_deg};
      REG_SH_LIMIT: prdata = {23'd0, lim_deg};
      default:      prdata = '0;
    endcase
  end

  // link terms, recomputed every cycle from the registers
  logic [27:0] l12, l11, l22;
  logic [14:0] lsum;
  logic [28:0] cfg_d, cfg_q;
  logic [29:0] cfg_reach;
  logic [4:0]  cfg_k, blen;

  assign l12  = l1 * l2;
  assign l11  = l1 * l1;
  assign l22  = l2 * l2;
  assign lsum = {1'b0, l1} + {1'b0, l2};

  always_comb begin
    blen = '0;
    for (int i = 0; i < 29; i++) begin
      if (cfg_d[i]) blen = 5'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    cfg_d     <= {l12, 1'b0};
    cfg_q     <= {1'b0, l11} + {1'b0, l22};
    cfg_reach <= lsum * lsum;
    cfg_k     <= 5'(6'd31 - {1'b0, blen});  // D scaled into [2^30, 2^31)
  end

  // ---------------- pipeline control ----------------
  logic vld [1:S_OUT];
  logic en;

  assign en       = !vld[S_OUT] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[S_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= S_OUT; s++) vld[s] <= 1'b0;
    end else if (en) begin
      vld[1] <= s_tvalid;
      for (int s = 2; s <= S_OUT; s++) vld[s] <= vld[s-1];
    end
  end

  // side lines travelling with each word
  logic [2*CB-1:0]   xy_d  [1:S_SUM];
  logic              org_d [1:S_R3];
  logic              bey_d [4:S_R3];
  logic signed [31:0] cs_d [S_UV:S_SUM];
  logic [31:0]        ds_d [S_UV:S_SQE];

  always_ff @(posedge clk) begin
    if (en) begin
      xy_d[1]  <= s_tdata[2*CB-1:0];
      org_d[1] <= (s_tdata[2*CB-1:0] == '0);
      for (int s = 2; s <= S_SUM; s++) xy_d[s] <= xy_d[s-1];
      for (int s = 2; s <= S_R3; s++) org_d[s] <= org_d[s-1];
    end
  end

  // ---------------- squared distance and cosine numerator ----------------
  logic [CB-1:0]   ax1, ay1;
  logic [2*CB-1:0] ax2, ay2;
  logic [2*CB:0]   r2;
  logic [RW-1:0]   r2e, qe, tdist;
  logic            ge4, cneg;
  logic [28:0]     cmag;
  logic [29:0]     dm, dp;
  logic [31:0]     u, v, cmk;
  logic [63:0]     prod;

  assign ax1 = xy_d[1][CB-1]   ? (~xy_d[1][CB-1:0] + 1'b1)    : xy_d[1][CB-1:0];
  assign ay1 = xy_d[1][2*CB-1] ? (~xy_d[1][2*CB-1:CB] + 1'b1) : xy_d[1][2*CB-1:CB];
  assign r2e = RW'(r2);
  assign qe  = RW'(cfg_q);
  assign dm  = cneg ? ({1'b0, cfg_d} + {1'b0, cmag}) : ({1'b0, cfg_d} - {1'b0, cmag});
  assign dp  = cneg ? ({1'b0, cfg_d} - {1'b0, cmag}) : ({1'b0, cfg_d} + {1'b0, cmag});
  assign cmk = 32'(cmag) << cfg_k;

  always_ff @(posedge clk) begin
    if (en) begin
      ax2      <= ax1 * ax1;
      ay2      <= ay1 * ay1;
      r2       <= {1'b0, ax2} + {1'b0, ay2};
      bey_d[4] <= r2e > RW'(cfg_reach);
      ge4      <= r2e >= qe;
      tdist    <= (r2e >= qe) ? (r2e - qe) : (qe - r2e);
      cmag     <= (tdist > RW'(cfg_d)) ? cfg_d : tdist[28:0];
      cneg     <= !ge4;
      u        <= 32'(dm) << cfg_k;
      v        <= 32'(dp) << cfg_k;
      cs_d[S_UV] <= cneg ? -$signed(cmk) : $signed(cmk);
      ds_d[S_UV] <= 32'(cfg_d) << cfg_k;
      prod     <= u * v;   // D'^2 - C'^2, below 2^62
      for (int s = 5; s <= S_R3; s++) bey_d[s] <= bey_d[s-1];
      for (int s = S_UV + 1; s <= S_SUM; s++) cs_d[s] <= cs_d[s-1];
      for (int s = S_UV + 1; s <= S_SQE; s++) ds_d[s] <= ds_d[s-1];
    end
  end

  // ---------------- sine term: restoring square root ----------------
  logic [33:0]      sq_rem  [0:SQ_STEPS-1];
  logic [30:0]      sq_root [0:SQ_STEPS-1];
  logic [RAD_W-1:0] sq_rad  [0:SQ_STEPS-1];

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    logic [33:0]      p_rem, remsh, trial;
    logic [30:0]      p_root;
    logic [RAD_W-1:0] p_rad;
    if (i == 0) begin : g_first
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_rad  = prod[RAD_W-1:0];
    end else begin : g_next
      assign p_rem  = sq_rem[i-1];
      assign p_root = sq_root[i-1];
      assign p_rad  = sq_rad[i-1];
    end
    assign remsh = {p_rem[31:0], p_rad[RAD_W-1:RAD_W-2]};
    assign trial = {1'b0, p_root, 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rad[i] <= {p_rad[RAD_W-3:0], 2'b00};
        if (remsh >= trial) begin
          sq_rem[i]  <= remsh - trial;
          sq_root[i] <= {p_root[29:0], 1'b1};
        end else begin
          sq_rem[i]  <= remsh;
          sq_root[i] <= {p_root[29:0], 1'b0};
        end
      end
    end
  end

  // ---------------- shoulder correction vector ----------------
  logic [30:0]               ss39, ss40;
  logic [44:0]               pa, pb;
  logic signed [46:0]        pc;
  logic signed [ATAN_W-1:0]  xb, yb;

  always_ff @(posedge clk) begin
    if (en) begin
      ss39 <= sq_root[SQ_STEPS-1];
      pa   <= l2 * sq_root[SQ_STEPS-1];
      pb   <= l1 * ds_d[S_SQE][30:0];
      pc   <= $signed({1'b0, l2}) * cs_d[S_SQE];
      ss40 <= ss39;
      xb   <= ATAN_W'(pc) + ATAN_W'({1'b0, pb});
      yb   <= ATAN_W'({1'b0, pa});
    end
  end

  // ---------------- three atan2 units in parallel ----------------
  logic signed [ZW-1:0] ze, za, zb;

  tlik_atan2 u_atan_elbow (
    .clk (clk),
    .en  (en),
    .y   (ATAN_W'({1'b0, ss40})),
    .x   (ATAN_W'(cs_d[S_SUM])),
    .z   (ze)
  );

  tlik_atan2 u_atan_target (
    .clk (clk),
    .en  (en),
    .y   (ATAN_W'($signed(xy_d[S_SUM][2*CB-1:CB]))),
    .x   (ATAN_W'($signed(xy_d[S_SUM][CB-1:0]))),
    .z   (za)
  );

  tlik_atan2 u_atan_corr (
    .clk (clk),
    .en  (en),
    .y   (yb),
    .x   (xb),
    .z   (zb)
  );

  // ---------------- rounding, wrap, limits ----------------
  logic signed [ZW:0]     diff, ze_r;
  logic signed [ER_W-1:0] er, shr, wrp;
  logic [13:0]            el2, el3;
  logic [14:0]            shw;
  logic [14:0]            lim, sh_pre, sh_f;
  logic [13:0]            e_ang, el_b, el_c, el_f;
  logic                   clamped, bent, ext;
  logic [14:0]            o_sh;
  logic [13:0]            o_el;
  logic [3:0]             o_flags;

  assign ze_r = (ZW+1)'(ze) + (ZW+1)'(512);

  always_comb begin
    if (shr < 0) begin
      if (shr + ER_W'(FULL_TURN) >= 0) wrp = shr + ER_W'(FULL_TURN);
      else                             wrp = shr + ER_W'(2 * FULL_TURN);
    end else if (shr >= ER_W'(FULL_TURN)) begin
      wrp = shr - ER_W'(FULL_TURN);
    end else begin
      wrp = shr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // R1: beyond reach points straight at the target
      diff <= bey_d[S_AT] ? (ZW+1)'(za) : (ZW+1)'(za) - (ZW+1)'(zb);
      er   <= ER_W'(ze_r >>> 10);
      // R2
      shr  <= ER_W'((diff + (ZW+1)'(512)) >>> 10);
      if (cfg_d == '0 || er < 0) el2 <= '0;
      else if (er > ER_W'(HALF_TURN)) el2 <= 14'(HALF_TURN);
      else el2 <= er[13:0];
      // R3
      shw  <= wrp[14:0];
      el3  <= el2;
    end
  end

  // final stage: origin, shoulder limit, then bent and extended margins
  always_comb begin
    lim     = {lim_deg, 6'd0};
    e_ang   = {2'd0, ofs_deg, 6'd0};
    sh_pre  = (org_d[S_R3] && !bey_d[S_R3]) ? '0 : shw;
    clamped = sh_pre > lim;
    sh_f    = clamped ? lim : sh_pre;
    el_b    = bey_d[S_R3] ? e_ang : el3;
    bent    = (14'(HALF_TURN) - el_b) < e_ang;
    el_c    = bent ? (14'(HALF_TURN) - e_ang) : el_b;
    ext     = el_c < e_ang;
    el_f    = ext ? e_ang : el_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_sh    <= sh_f;
      o_el    <= el_f;
      o_flags <= {ext, bent, clamped, bey_d[S_R3]};
    end
  end

  assign m_tdata = {3'd0, o_el, o_sh};
  assign m_tuser = o_flags;

  // ---------------- checks ----------------
  a_elbow_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (o_el <= 14'(HALF_TURN)))
    else $error("elbow angle above half turn");

  a_shoulder_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (o_sh < 15'(FULL_TURN)))
    else $error("shoulder angle not wrapped");

  a_sing_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(o_flags[2] && o_flags[3]))
    else $error("both elbow margins applied");

endmodule

`default_nettype wire

>>> tb/ik_checker.sv
// Checker for the two-link arm IK block: tracks register writes on the APB port,
// predicts each result word from accepted targets and compares it on the output.
// Depends on tlik_pkg for the register indexes and the CORDIC angle table.
`timescale 1ns / 1ps

module ik_checker import tlik_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [31:0] s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [31:0] m_tdata,
  input  wire logic [3:0]  m_tuser,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               outstanding,
  output int               fails
);

  typedef struct packed {
    logic [31:0] angles;  // shoulder [14:0], elbow [28:15]
    logic [3:0]  flags;   // beyond, clamped, bent, extended
  } joint_word_t;

  logic [13:0] len_one, len_two;
  logic [5:0]  sing_margin;
  logic [8:0]  sh_limit;
  joint_word_t pending_angles[$];

  function automatic longint unsigned mag(longint v);
    return v >= 0 ? v : -v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // vectoring CORDIC, result in 2^-16 degree
  function automatic longint vec_angle(longint y, longint x);
    longint z, nx, ny;
    longint unsigned m;
    z = 0;
    if (y == 0) return x < 0 ? 180 * ANG_ONE : 0;
    if (x == 0) return y > 0 ? 90 * ANG_ONE : -90 * ANG_ONE;
    m = mag(x) > mag(y) ? mag(x) : mag(y);
    while (m >= (64'd1 << 30)) begin
      x = x >>> 1;
      y = y >>> 1;
      m = mag(x) > mag(y) ? mag(x) : mag(y);
    end
    while (m < (64'd1 << 29)) begin
      x = x * 2; y = y * 2; m = m * 2;
    end
    if (x < 0) begin
      x = -x; y = -y; z = 180 * ANG_ONE;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += longint'(ATAN_TAB[i]);
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= longint'(ATAN_TAB[i]);
      end
      x = nx; y = ny;
    end
    return z;
  endfunction

  function automatic longint to_64th(longint z);
    return (z + 512) >>> 10;
  endfunction

  function automatic longint wrap(longint a);
    a = a % FULL_TURN;
    if (a < 0) a += FULL_TURN;
    return a;
  endfunction

  function automatic joint_word_t solve_arm(logic signed [15:0] tx, logic signed [15:0] ty);
    longint x, y, cnum, cs, ss, ds, elbow, shoulder, e, lim;
    longint unsigned r2, l1, l2, d, q, reach, t;
    int k;
    logic beyond, clamped, bent, extended;
    joint_word_t w;
    x = tx; y = ty;
    r2 = mag(x) * mag(x) + mag(y) * mag(y);
    l1 = len_one; l2 = len_two;
    d = 2 * l1 * l2; q = l1 * l1 + l2 * l2;
    reach = (l1 + l2) * (l1 + l2);
    e = longint'(sing_margin) * 64;
    lim = longint'(sh_limit) * 64;
    cs = 0; ss = 0; ds = 0; elbow = 0;
    beyond = r2 > reach; clamped = 0; bent = 0; extended = 0;
    if (d != 0) begin
      if (r2 >= q) begin
        t = r2 - q; cnum = t > d ? d : t;
      end else begin
        t = q - r2; cnum = -longint'(t > d ? d : t);
      end
      k = 0;
      while ((d << k) < (64'd1 << 30)) k++;
      ss = int_sqrt((longint'(d) - cnum) * (longint'(d) + cnum) << (2 * k));
      cs = cnum * (longint'(1) << k);
      ds = d << k;
      elbow = to_64th(vec_angle(ss, cs));
      if (elbow < 0) elbow = 0;
      if (elbow > HALF_TURN) elbow = HALF_TURN;
    end
    if (beyond) begin
      shoulder = wrap(to_64th(vec_angle(y, x)));
      elbow = e;
    end else if (x == 0 && y == 0) begin
      shoulder = 0;
    end else begin
      shoulder = wrap(to_64th(vec_angle(y, x) -
                              vec_angle(longint'(l2) * ss,
                                        longint'(l1) * ds + longint'(l2) * cs)));
    end
    if (shoulder > lim) begin shoulder = lim; clamped = 1; end
    if (HALF_TURN - elbow < e) begin elbow = HALF_TURN - e; bent = 1; end
    if (elbow < e) begin elbow = e; extended = 1; end
    w.angles = {3'b000, elbow[13:0], shoulder[14:0]};
    w.flags  = {extended, bent, clamped, beyond};
    return w;
  endfunction

  assign outstanding = pending_angles.size();

  initial fails = 0;

  always @(posedge clk) begin
    joint_word_t want;
    if (rst) begin
      len_one <= 14'd6502;
      len_two <= 14'd6502;
      sing_margin <= 6'd10;
      sh_limit <= 9'd270;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_LINK_ONE: len_one <= pwdata[13:0];
          REG_LINK_TWO: len_two <= pwdata[13:0];
          REG_SING_OFS: sing_margin <= pwdata[5:0];
          REG_SH_LIMIT: sh_limit <= pwdata[8:0];
          default:      len_one <= len_one;
        endcase
      end
      if (s_tvalid && s_tready)
        pending_angles.push_back(solve_arm(s_tdata[15:0], s_tdata[31:16]));
      if (m_tvalid && m_tready) begin
        if (pending_angles.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected word: tdata %h tuser %b", m_tdata, m_tuser);
        end else begin
          want = pending_angles.pop_front();
          if (m_tdata !== want.angles || m_tuser !== want.flags) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: shoulder %0d/%0d elbow %0d/%0d flags %b/%b (exp/got)",
                       want.angles[14:0], m_tdata[14:0], want.angles[28:15],
                       m_tdata[28:15], want.flags, m_tuser);
          end
        end
      end
    end
  end

endmodule

>>> tb/testbench.sv
// Top of the IK block testbench: clock, reset, APB register phases and target stimulus.
// Depends on tlik_pkg, the block and ik_checker, which does all prediction and checks.
`timescale 1ns / 1ps

module testbench import tlik_pkg::*;;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;       // target_x [15:0], target_y [31:16]
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;            // shoulder [14:0], elbow [28:15], pad
  logic [3:0]  m_tuser;            // beyond, clamped, bent, extended
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          outstanding, fails;
  int          send_idle = 0, take_idle = 0;  // percent of cycles each side idles
  int          reach;                         // L1+L2 of the current setting

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  two_link_planar_inverse_kinematics dut (.*);

  ik_checker chk (.*);

  // output back-pressure, redrawn every cycle
  always @(negedge clk) m_tready <= ($urandom_range(99) >= take_idle);

  initial begin
    #5_000_000;
    $display("two_link_planar_inverse_kinematics verification failed");
    $finish;
  end

  task automatic drain();
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, int val);
    psel = 1; pwrite = 1; penable = 0; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  // only with the pipe empty; the pause covers the pipe and settling
  task automatic configure(int l1, int l2, int margin, int limit);
    s_tvalid = 0;
    drain();
    repeat (90) @(negedge clk);
    reg_write(REG_LINK_ONE, l1);
    reg_write(REG_LINK_TWO, l2);
    reg_write(REG_SING_OFS, margin);
    reg_write(REG_SH_LIMIT, limit);
    repeat (4) @(negedge clk);
    reach = l1 + l2;
  endtask

  // one target word, held until accepted
  task automatic send_target(int x, int y);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid = 0;
      @(negedge clk);
    end
    s_tvalid = 1;
    s_tdata = {y[15:0], x[15:0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic int clip(int v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  task automatic directed_targets();
    int r;
    r = clip(reach);
    send_target(0, 0);                  // origin
    send_target(32767, 32767);          // field extremes
    send_target(-32768, -32768);
    send_target(-32768, 32767);
    send_target(32767, -32768);
    send_target(r, 0);                  // fully stretched, on the axes
    send_target(0, r);
    send_target(-r, 0);
    send_target(0, -r);
    send_target(clip(reach + 1), 0);    // just out of reach
    send_target(r - 1, 1);              // just inside
    send_target(1, 0);                  // folded back on itself
    send_target(0, -1);
    send_target(-1, -1);
    send_target(r / 2, -(r / 2));       // shoulder near the top of its range
    send_target(-(r / 3), -(r / 4));
    send_target(r / 3, r / 5);
  endtask

  task automatic random_targets(int n);
    int lim, x, y, sel;
    lim = clip(reach);
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(9);
      if (sel < 6) begin                 // inside the square that bounds the workspace
        x = $urandom_range(2 * lim) - lim;
        y = $urandom_range(2 * lim) - lim;
      end else if (sel < 8) begin        // anywhere in the field range
        x = $signed($urandom_range(65535) - 32768);
        y = $signed($urandom_range(65535) - 32768);
      end else begin                     // on or near an axis
        x = $urandom_range(2 * lim) - lim;
        y = $urandom_range(2) - 1;
        if (sel == 9) begin
          y = x; x = $urandom_range(2) - 1;
        end
      end
      send_target(x, y);
    end
  endtask

  task automatic run_phase(int l1, int l2, int margin, int limit, int n);
    configure(l1, l2, margin, limit);
    directed_targets();
    random_targets(n / 2);
    // let the pipe run dry before carrying on
    s_tvalid = 0;
    drain();
    random_targets(n - n / 2);
  endtask

  initial begin
    reach = 13004;
    repeat (10) @(negedge clk);
    rst = 0;
    @(negedge clk);
    send_idle = 21; take_idle = 58;
    run_phase(6502, 6502, 10, 270, 50);
    run_phase(16383, 16383, 45, 360, 50);
    send_idle = 58; take_idle = 21;
    run_phase(1, 1, 0, 0, 50);
    run_phase($urandom_range(16383, 1), $urandom_range(16383, 1),
              $urandom_range(45), $urandom_range(360), 50);
    send_idle = 0; take_idle = 0;
    run_phase(3000, 9000, 20, 180, 50);
    run_phase($urandom_range(16383, 1), $urandom_range(8000, 1),
              $urandom_range(45), $urandom_range(360), 50);
    s_tvalid = 0;
    drain();
    repeat (100) @(negedge clk);
    if (fails == 0 && outstanding == 0)
      $display("two_link_planar_inverse_kinematics verification clean");
    else
      $display("two_link_planar_inverse_kinematics verification failed");
    $finish;
  end

endmodule
